// File: src/ps2_mouse_text_cursor_tracker_assert.svh
// assertion macros shared by the tracker modules
// both expect clk and rst to be visible in the calling scope
`ifndef PS2_MOUSE_TEXT_CURSOR_TRACKER_ASSERT_SVH
`define PS2_MOUSE_TEXT_CURSOR_TRACKER_ASSERT_SVH

// same-cycle implication
`define PS2MTC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ps2mtc check failed");

// next-cycle implication
`define PS2MTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ps2mtc check failed");

`endif

// File: src/ps2mtc_pkg.sv
`timescale 1ns / 1ps

package ps2mtc_pkg;

  // packet framing
  localparam int PACKET_LEN = 3;
  localparam int IDX_W      = 2;
  localparam int AUX_BIT    = 5;

  // datapath widths
  localparam int BYTE_W  = 8;
  localparam int ACC_W   = 9;
  localparam int DIVR_W  = 7;
  localparam int COORD_W = 8;
  localparam int EXT_W   = 11;

  // divider sequencing: one quotient bit per step
  localparam int DIV_STEPS = ACC_W;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  // configuration register indexes
  localparam logic [1:0] CFG_DIVISOR = 2'd0;
  localparam logic [1:0] CFG_COLUMNS = 2'd1;
  localparam logic [1:0] CFG_ROWS    = 2'd2;

  // reset values
  localparam logic [DIVR_W-1:0]  RST_DIVISOR = 7'd5;
  localparam logic [COORD_W-1:0] RST_COLUMNS = 8'd80;
  localparam logic [COORD_W-1:0] RST_ROWS    = 8'd25;
  localparam logic [COORD_W-1:0] RST_COL     = 8'd40;
  localparam logic [COORD_W-1:0] RST_ROW     = 8'd12;

  // packet collector status
  typedef struct packed {
    logic complete;
    logic moving;
  } pkt_stat_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // sign extend a motion byte to accumulator width
  function automatic logic signed [ACC_W-1:0] sign8(input logic [BYTE_W-1:0] b);
    return $signed({{(ACC_W-BYTE_W){b[BYTE_W-1]}}, b});
  endfunction

  // clamp a moved coordinate into 0 .. size-1, size of zero acts as one
  function automatic logic [COORD_W-1:0] clamp_coord(input logic signed [EXT_W-1:0] v,
                                                     input logic [COORD_W-1:0] size);
    logic [COORD_W-1:0] lim;
    lim = (size == '0) ? '0 : size - 1'b1;
    if (v > $signed({{(EXT_W-COORD_W){1'b0}}, lim})) begin
      return lim;
    end else if (v < 0) begin
      return '0;
    end else begin
      return v[COORD_W-1:0];
    end
  endfunction

endpackage

// File: src/ps2_mouse_text_cursor_tracker.sv
`timescale 1ns / 1ps

// a packet-completing request with motion runs the shared 9-step divider for x, then y
// a moving packet's last request holds the input until its result is registered
// other requests leave the input ready for the next one
// a finished result may wait in the output register while new requests arrive
// synchronous reset: cursor at column 40 row 12, accumulators zero, config 5/80/25

module ps2_mouse_text_cursor_tracker
  import ps2mtc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [BYTE_W-1:0]  ctrl_status,
  input  logic [BYTE_W-1:0]  data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COORD_W-1:0] old_col,
  output logic [COORD_W-1:0] old_row,
  output logic [COORD_W-1:0] new_col,
  output logic [COORD_W-1:0] new_row,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [BYTE_W-1:0]  cfg_data
);

`include "ps2_mouse_text_cursor_tracker_assert.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SX   = 3'd1;
  localparam logic [2:0] ST_WX   = 3'd2;
  localparam logic [2:0] ST_SY   = 3'd3;
  localparam logic [2:0] ST_WY   = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  logic [2:0]               state;
  logic [DIVR_W-1:0]        motion_divisor;
  logic [COORD_W-1:0]       screen_columns;
  logic [COORD_W-1:0]       screen_rows;
  logic signed [ACC_W-1:0]  accum_horiz;
  logic signed [ACC_W-1:0]  accum_vert;
  logic signed [ACC_W-1:0]  acc_work;
  logic [COORD_W-1:0]       cursor_col;
  logic [COORD_W-1:0]       cursor_row;
  logic [COORD_W-1:0]       old_col_hold;
  logic [COORD_W-1:0]       old_row_hold;
  logic [BYTE_W-1:0]        dy_hold;

  logic                     in_acc;
  logic                     aux_acc;
  logic                     start_move;
  pkt_stat_t                pkt_stat;
  logic [BYTE_W-1:0]        pkt_dx;
  logic [BYTE_W-1:0]        pkt_dy;

  div_stat_t                div_stat;
  logic                     div_start;
  logic [DIVR_W-1:0]        div_eff;
  logic                     acc_neg;
  logic [ACC_W-1:0]         acc_mag;
  logic [ACC_W-1:0]         div_quot;
  logic [DIVR_W-1:0]        div_rem;
  logic signed [EXT_W-1:0]  q_signed;
  logic signed [ACC_W-1:0]  rem_signed;
  logic signed [EXT_W-1:0]  col_sum;
  logic signed [EXT_W-1:0]  row_sum;

  // handshakes
  assign in_ready   = (state == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign in_acc     = in_valid && in_ready;
  assign aux_acc    = in_acc && ctrl_status[AUX_BIT];
  assign start_move = aux_acc && pkt_stat.complete && pkt_stat.moving;

  // packet collector
  ps2mtc_packet u_packet (
    .clk    (clk),
    .rst    (rst),
    .accept (aux_acc),
    .data   (data_byte),
    .stat   (pkt_stat),
    .dx     (pkt_dx),
    .dy     (pkt_dy)
  );

  // sign-magnitude around the shared unsigned divider
  assign div_eff   = (motion_divisor == '0) ? DIVR_W'(1) : motion_divisor;
  assign acc_neg   = acc_work[ACC_W-1];
  assign acc_mag   = acc_neg ? ACC_W'(-acc_work) : ACC_W'(acc_work);
  assign div_start = (state == ST_SX) || (state == ST_SY);

  ps2mtc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc_mag),
    .divisor  (div_eff),
    .stat     (div_stat),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // truncated quotient and remainder carry the dividend's sign
  always_comb begin
    q_signed   = $signed({{(EXT_W-ACC_W){1'b0}}, div_quot});
    rem_signed = $signed({{(ACC_W-DIVR_W){1'b0}}, div_rem});
    if (acc_neg) begin
      q_signed   = -q_signed;
      rem_signed = -rem_signed;
    end
  end

  assign col_sum = $signed({{(EXT_W-COORD_W){1'b0}}, cursor_col}) + q_signed;
  assign row_sum = $signed({{(EXT_W-COORD_W){1'b0}}, cursor_row}) + q_signed;

  // configuration, sequencer and cursor state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      motion_divisor <= RST_DIVISOR;
      screen_columns <= RST_COLUMNS;
      screen_rows    <= RST_ROWS;
      accum_horiz    <= '0;
      accum_vert     <= '0;
      cursor_col     <= RST_COL;
      cursor_row     <= RST_ROW;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_DIVISOR: motion_divisor <= cfg_data[DIVR_W-1:0];
          CFG_COLUMNS: screen_columns <= cfg_data;
          CFG_ROWS:    screen_rows    <= cfg_data;
          default: ;
        endcase
      end

      // a result leaving while none replaces it
      if (out_valid && out_ready && (state != ST_FIN)) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (start_move) begin
            acc_work     <= accum_horiz + sign8(pkt_dx);
            dy_hold      <= pkt_dy;
            old_col_hold <= cursor_col;
            old_row_hold <= cursor_row;
            state        <= ST_SX;
          end
        end
        ST_SX: begin
          state <= ST_WX;
        end
        ST_WX: begin
          if (div_stat.done) begin
            accum_horiz <= rem_signed;
            cursor_col  <= clamp_coord(col_sum, screen_columns);
            acc_work    <= accum_vert - sign8(dy_hold);
            state       <= ST_SY;
          end
        end
        ST_SY: begin
          state <= ST_WY;
        end
        ST_WY: begin
          if (div_stat.done) begin
            accum_vert <= rem_signed;
            cursor_row <= clamp_coord(row_sum, screen_rows);
            state      <= ST_FIN;
          end
        end
        ST_FIN: begin
          if (!out_valid || out_ready) begin
            old_col   <= old_col_hold;
            old_row   <= old_row_hold;
            new_col   <= cursor_col;
            new_row   <= cursor_row;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `PS2MTC_ASSERT_IMP(a_done_while_waiting, div_stat.done, (state == ST_WX) || (state == ST_WY))
  `PS2MTC_ASSERT_IMP(a_busy_while_waiting, div_stat.busy, (state == ST_WX) || (state == ST_WY))
  `PS2MTC_ASSERT_NEXT(a_move_starts_x, start_move, state == ST_SX)
  `PS2MTC_ASSERT_NEXT(a_fin_delivers, (state == ST_FIN) && (!out_valid || out_ready), out_valid)

endmodule

// File: src/ps2mtc_packet.sv
`timescale 1ns / 1ps

module ps2mtc_packet
  import ps2mtc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [BYTE_W-1:0] data,
  output pkt_stat_t         stat,
  output logic [BYTE_W-1:0] dx,
  output logic [BYTE_W-1:0] dy
);

  logic [IDX_W-1:0]  byte_index;
  logic [IDX_W-1:0]  idx_eff;
  logic [BYTE_W-1:0] x_byte;

  // stray index falls back to the first byte
  assign idx_eff = (byte_index >= IDX_W'(PACKET_LEN)) ? '0 : byte_index;

  // last byte of a packet carries y, x is held from the previous request
  assign dx            = x_byte;
  assign dy            = data;
  assign stat.complete = (idx_eff == IDX_W'(PACKET_LEN - 1));
  assign stat.moving   = (x_byte != '0) || (data != '0);

  // byte position and x delta capture
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
    end else if (accept) begin
      if (idx_eff == IDX_W'(1)) begin
        x_byte <= data;
      end
      byte_index <= stat.complete ? '0 : idx_eff + 1'b1;
    end
  end

endmodule

// File: src/ps2mtc_div.sv
`timescale 1ns / 1ps

module ps2mtc_div
  import ps2mtc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [ACC_W-1:0]  dividend,
  input  logic [DIVR_W-1:0] divisor,
  output div_stat_t         stat,
  output logic [ACC_W-1:0]  quot,
  output logic [DIVR_W-1:0] rem
);

`include "ps2_mouse_text_cursor_tracker_assert.svh"

  logic [ACC_W-1:0]  shift;
  logic [DIVR_W-1:0] partial;
  logic [DIVR_W-1:0] div_reg;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic              done;
  logic [DIVR_W:0]   trial;
  logic              fits;

  // one restoring step: bring down the next dividend bit and try the divisor
  assign trial = {partial, shift[ACC_W-1]};
  assign fits  = (trial >= {1'b0, div_reg});

  assign stat.busy = busy;
  assign stat.done = done;
  assign quot      = shift;
  assign rem       = partial;

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        shift   <= dividend;
        partial <= '0;
        div_reg <= divisor;
        cnt     <= CNT_W'(DIV_STEPS);
        busy    <= 1'b1;
      end else if (busy) begin
        partial <= fits ? DIVR_W'(trial - {1'b0, div_reg}) : trial[DIVR_W-1:0];
        shift   <= {shift[ACC_W-2:0], fits};
        cnt     <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  `PS2MTC_ASSERT_IMP(a_rem_below_divisor, done, partial < div_reg)
  `PS2MTC_ASSERT_IMP(a_done_not_busy, done, !busy)
  `PS2MTC_ASSERT_NEXT(a_start_goes_busy, start, busy)

endmodule

// File: verif/ps2_mouse_text_cursor_tracker_tb.sv
`timescale 1ns / 1ps

module ps2_mouse_text_cursor_tracker_tb;
  import ps2mtc_pkg::*;

  // register index with no register behind it, writes are dropped
  localparam logic [1:0] CFG_SPARE = 2'd3;
  // idle time after the last move before touching config or ending
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES = 8;
  localparam int EVENTS_PER_PHASE = 100;
  localparam int DIR_COUNT = 21;

  typedef struct packed {
    logic [COORD_W-1:0] old_col;
    logic [COORD_W-1:0] old_row;
    logic [COORD_W-1:0] new_col;
    logic [COORD_W-1:0] new_row;
  } cell_move_t;

  typedef struct packed {
    logic [BYTE_W-1:0] status;
    logic [BYTE_W-1:0] data;
    logic              typed;
    cell_move_t        move;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic [BYTE_W-1:0]  ctrl_status;
  logic [BYTE_W-1:0]  data_byte;
  logic               out_valid;
  logic               out_ready;
  logic [COORD_W-1:0] old_col;
  logic [COORD_W-1:0] old_row;
  logic [COORD_W-1:0] new_col;
  logic [COORD_W-1:0] new_row;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [1:0]         cfg_index;
  logic [BYTE_W-1:0]  cfg_data;

  // tracker mirror: configuration
  logic [DIVR_W-1:0]  divisor;
  logic [COORD_W-1:0] columns;
  logic [COORD_W-1:0] rows;
  // tracker mirror: packet framing, accumulators, cursor
  logic [IDX_W-1:0]   pkt_pos;
  logic [BYTE_W-1:0]  pkt [PACKET_LEN];
  int                 acc_h;
  int                 acc_v;
  logic [COORD_W-1:0] cur_col;
  logic [COORD_W-1:0] cur_row;

  cell_move_t pending_moves [$];
  int         fail_count;
  bit         no_gaps;

  // directed rows: ignored events, zero motion, extremes of both deltas, clamping
  dir_row_t dir_rows [DIR_COUNT] = '{
    '{8'h00, 8'h55, 1'b0, 32'h0},
    '{8'hDF, 8'hFF, 1'b0, 32'h0},
    '{8'h20, 8'h08, 1'b0, 32'h0},
    '{8'h20, 8'h05, 1'b0, 32'h0},
    '{8'h20, 8'h00, 1'b1, 32'h280C_290C},
    '{8'h3F, 8'hFF, 1'b0, 32'h0},
    '{8'h20, 8'h00, 1'b0, 32'h0},
    '{8'h20, 8'h00, 1'b0, 32'h0},
    '{8'hFF, 8'h00, 1'b0, 32'h0},
    '{8'hFF, 8'h7F, 1'b0, 32'h0},
    '{8'hFF, 8'h80, 1'b1, 32'h290C_4218},
    '{8'h20, 8'hC8, 1'b0, 32'h0},
    '{8'h20, 8'h80, 1'b0, 32'h0},
    '{8'h20, 8'h7F, 1'b1, 32'h4218_2900},
    '{8'h20, 8'h00, 1'b0, 32'h0},
    '{8'h20, 8'h01, 1'b0, 32'h0},
    '{8'h20, 8'h01, 1'b0, 32'h0},
    '{8'h60, 8'h00, 1'b0, 32'h0},
    '{8'h00, 8'h44, 1'b0, 32'h0},
    '{8'h20, 8'h00, 1'b0, 32'h0},
    '{8'hA0, 8'hFF, 1'b0, 32'h0}
  };

  ps2_mouse_text_cursor_tracker u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ctrl_status(ctrl_status),
    .data_byte  (data_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .old_col    (old_col),
    .old_row    (old_row),
    .new_col    (new_col),
    .new_row    (new_row),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  // whole cell steps out of one accumulator, remainder stays behind
  function automatic int cell_steps(inout int acc, input int div);
    int q;
    q = 0;
    if (acc >= div || acc <= -div) begin
      q = acc / div;
      acc = acc - q * div;
    end
    return q;
  endfunction

  // keep a moved coordinate on screen, a size of zero pins it to 0
  function automatic logic [COORD_W-1:0] fit_coord(input int v, input logic [COORD_W-1:0] size);
    int lim;
    lim = (size == '0) ? 0 : int'(size) - 1;
    if (v > lim) v = lim;
    if (v < 0) v = 0;
    return v[COORD_W-1:0];
  endfunction

  // feed one controller event to the mirror, returns 1 when the cursor cells are reported
  function automatic bit track_event(input logic [BYTE_W-1:0] status,
                                     input logic [BYTE_W-1:0] data,
                                     output cell_move_t mv);
    int div;
    int dx;
    int dy;
    mv = '0;
    if (!status[AUX_BIT]) return 1'b0;
    if (pkt_pos >= PACKET_LEN) pkt_pos = '0;
    pkt[pkt_pos] = data;
    pkt_pos = pkt_pos + 1'b1;
    if (pkt_pos >= PACKET_LEN) pkt_pos = '0;
    if (pkt_pos != '0) return 1'b0;
    if (pkt[1] == '0 && pkt[2] == '0) return 1'b0;
    div = (divisor == '0) ? 1 : int'(divisor);
    dx = $signed(pkt[1]);
    dy = $signed(pkt[2]);
    mv.old_col = cur_col;
    mv.old_row = cur_row;
    acc_h = acc_h + dx;
    cur_col = fit_coord(int'(cur_col) + cell_steps(acc_h, div), columns);
    acc_v = acc_v - dy;
    cur_row = fit_coord(int'(cur_row) + cell_steps(acc_v, div), rows);
    mv.new_col = cur_col;
    mv.new_row = cur_row;
    return 1'b1;
  endfunction

  // motion byte: some small, some zero, some any value, some at the extremes
  function automatic logic [BYTE_W-1:0] motion_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 25) return 8'h00;
    if (pick < 40) begin
      case ($urandom_range(0, 4))
        0: return 8'h7F;
        1: return 8'h80;
        2: return 8'h81;
        3: return 8'h01;
        default: return 8'hFF;
      endcase
    end
    if (pick < 70) return BYTE_W'($urandom_range(0, 255));
    return BYTE_W'($signed($urandom_range(0, 24)) - 12);
  endfunction

  function automatic void note_fail(input string msg);
    if (fail_count < 10) $display("%0t: %s", $realtime, msg);
    fail_count++;
  endfunction

  // one event request, at times with a random gap ahead of it
  task automatic push_event(input logic [BYTE_W-1:0] status, input logic [BYTE_W-1:0] data,
                            input bit typed, input cell_move_t typed_move);
    int gap;
    cell_move_t mv;
    gap = 0;
    if (!no_gaps && $urandom_range(0, 99) < 27) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    ctrl_status <= status;
    data_byte   <= data;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (track_event(status, data, mv)) pending_moves.push_back(typed ? typed_move : mv);
  endtask

  // one register write, the caller drops cfg_valid after the last one
  task automatic write_reg(input logic [1:0] idx, input logic [BYTE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_DIVISOR: divisor = val[DIVR_W-1:0];
      CFG_COLUMNS: columns = val;
      CFG_ROWS:    rows    = val;
      default: ;
    endcase
  endtask

  // wait for every outstanding move, then let the divider go quiet
  task automatic settle();
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= no_gaps || ($urandom_range(0, 99) >= 27);
  end

  // compare each reported move with the oldest pending one
  always @(posedge clk) begin : check_moves
    cell_move_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_moves.size() == 0) begin
        note_fail($sformatf("unexpected move %0d,%0d -> %0d,%0d",
                            old_col, old_row, new_col, new_row));
      end else begin
        want = pending_moves.pop_front();
        if (old_col !== want.old_col || old_row !== want.old_row ||
            new_col !== want.new_col || new_row !== want.new_row) begin
          note_fail($sformatf("move mismatch: want %0d,%0d -> %0d,%0d got %0d,%0d -> %0d,%0d",
                              want.old_col, want.old_row, want.new_col, want.new_row,
                              old_col, old_row, new_col, new_row));
        end
      end
    end
  end

  // stimulus
  initial begin
    logic [DIVR_W+1+2*COORD_W-1:0] settings [PHASES];
    logic [BYTE_W-1:0] div_w;
    logic [BYTE_W-1:0] col_w;
    logic [BYTE_W-1:0] row_w;
    logic [BYTE_W-1:0] st;
    logic [BYTE_W-1:0] db;
    int n;

    rst         <= 1'b1;
    in_valid    <= 1'b0;
    ctrl_status <= '0;
    data_byte   <= '0;
    out_ready   <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= CFG_DIVISOR;
    cfg_data    <= '0;
    fail_count  = 0;
    no_gaps     = 1'b0;
    divisor     = RST_DIVISOR;
    columns     = RST_COLUMNS;
    rows        = RST_ROWS;
    pkt_pos     = '0;
    pkt         = '{default: '0};
    acc_h       = 0;
    acc_v       = 0;
    cur_col     = RST_COL;
    cur_row     = RST_ROW;

    // divisor / columns / rows per phase, divisor written as a full byte
    settings[0] = {8'd5,   8'd80,  8'd25};
    settings[1] = {8'd0,   8'd0,   8'd0};
    settings[2] = {8'hFF,  8'd255, 8'd255};
    settings[3] = {8'd2,   8'd1,   8'd255};
    settings[4] = {8'd64,  8'd255, 8'd1};
    settings[5] = {8'h85,  8'd10,  8'd200};
    settings[6] = {8'd1,   8'd40,  8'd12};
    settings[7] = {8'(($urandom_range(2, 64))), 8'(($urandom_range(1, 255))),
                   8'(($urandom_range(1, 255)))};

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table under reset configuration
    for (int r = 0; r < DIR_COUNT; r++) begin
      push_event(dir_rows[r].status, dir_rows[r].data, dir_rows[r].typed, dir_rows[r].move);
    end

    // random phases, each behind a drained pipe and a fresh configuration
    for (int p = 0; p < PHASES; p++) begin
      in_valid <= 1'b0;
      settle();
      {div_w, col_w, row_w} = settings[p];
      write_reg(CFG_DIVISOR, div_w);
      write_reg(CFG_COLUMNS, col_w);
      write_reg(CFG_ROWS, row_w);
      if (p == 2) write_reg(CFG_SPARE, BYTE_W'($urandom_range(0, 255)));
      cfg_valid <= 1'b0;
      no_gaps = (p == 3);
      n = 0;
      while (n < EVENTS_PER_PHASE) begin
        if ($urandom_range(0, 99) < 10) begin
          // keyboard traffic, the tracker ignores it
          st = BYTE_W'($urandom_range(0, 255)) & ~8'h20;
          db = BYTE_W'($urandom_range(0, 255));
        end else begin
          st = BYTE_W'($urandom_range(0, 255)) | 8'h20;
          db = (pkt_pos == '0) ? BYTE_W'($urandom_range(0, 255)) : motion_byte();
          n++;
        end
        push_event(st, db, 1'b0, '0);
      end
    end
    no_gaps = 1'b0;

    in_valid <= 1'b0;
    settle();
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
